// ----- design/stli_pkg.sv -----
// Package for the sorted table log interpolator.
// Shared widths, status codes and default parameter values.
// No dependencies.
package stli_pkg;
   localparam int DATA_W        = 24;
   localparam int CFG_W         = 24;
   localparam int CNT_W         = 9;
   localparam int INDEX_W       = 8;
   localparam int DEF_DEPTH     = 256;
   localparam int DEF_FRAC_BITS = 16;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_DUP   = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_COUNT   = 2'd0,
      REG_KEY_OFS = 2'd1,
      REG_VAL_OFS = 2'd2
   } reg_index_type;
endpackage

// ----- design/sorted_table_log_interpolator.sv -----
// Top level of the sorted table log interpolator.
// Holds the key/value table memories, the search sequencer and the divider.
// Depends on stli_pkg.
// A write stores the entry in S_WRITE and responds from S_DONE. A query reads
// the first and last keys, binary-searches for the bracketing pair, reads it,
// then multiplies and divides; an empty table, a key below the first or above
// the last key, or a duplicate pair ends it early. The divider is restoring, one quotient bit per cycle.
// One transaction at a time; busy is high from accept through the result edge,
// and the next start can be taken while rsp_valid is high.
// Reset is synchronous, active high; it clears the control state and the
// configuration registers. Table contents are undefined until written.
// Results appear for one cycle on rsp_valid; the receiver cannot stall.
module sorted_table_log_interpolator #(
   parameter int TABLE_DEPTH = stli_pkg::DEF_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_action,
   input  logic [stli_pkg::INDEX_W-1:0]      req_entry_index,
   input  logic signed [stli_pkg::DATA_W-1:0] req_entry_key,
   input  logic signed [stli_pkg::DATA_W-1:0] req_entry_value,
   input  logic signed [stli_pkg::DATA_W-1:0] req_query_key,
   output logic                              rsp_valid,
   output logic signed [stli_pkg::DATA_W-1:0] rsp_log_result,
   output logic [1:0]                        rsp_status,
   input  logic                              csr_write,
   input  logic [1:0]                        csr_index,
   input  logic [stli_pkg::CFG_W-1:0]        csr_data
);
   localparam int DW = stli_pkg::DATA_W;
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = stli_pkg::CNT_W;
   // x and key differences need 26 bits, product 51, quotient up to ~51
   localparam int XW = DW + 2;
   localparam int HW = XW / 2;
   localparam int PW = 2 * XW;
   localparam int QW = PW;
   localparam int QCW = $clog2(QW + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_WRITE, S_RD_FIRST, S_CHK_FIRST, S_RD_LAST, S_CHK_LAST,
      S_PROBE, S_CMP, S_RD_PAIR, S_DIFF, S_MUL, S_DIV, S_DONE
   } state_type;

   // configuration
   logic [CW-1:0]        count_ff;
   logic signed [DW-1:0] key_ofs_ff, val_ofs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         key_ofs_ff <= '0;
         val_ofs_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            stli_pkg::REG_COUNT:   count_ff   <= csr_data[CW-1:0];
            stli_pkg::REG_KEY_OFS: key_ofs_ff <= csr_data[DW-1:0];
            stli_pkg::REG_VAL_OFS: val_ofs_ff <= csr_data[DW-1:0];
            default: ;
         endcase
      end
   end

   state_type            state_ff;
   logic [stli_pkg::INDEX_W-1:0] idx_ff;
   logic signed [DW-1:0] req_key_ff, req_val_ff;
   logic signed [XW-1:0] x_ff;
   logic [AW-1:0]        lo_ff, hi_ff, mid_ff, addr_ff;
   logic [CW-1:0]        n_ff;
   logic signed [XW-1:0] key_lo_ff, dk_ff, dx_ff, dv_ff;
   logic signed [DW-1:0] val_lo_ff;
   logic                 neg_ff;
   logic [XW-1:0]        mx_ff;      // |dx|
   logic [XW-1:0]        mv_ff;      // |dv|
   logic [PW-1:0]        num_ff;     // |product| + d/2
   logic [XW-1:0]        den_ff;     // |dk|
   logic [PW:0]          rem_ff;
   logic [QW-1:0]        quo_ff;
   logic [QCW-1:0]       cnt_ff;
   logic signed [DW-1:0] res_ff;
   logic [1:0]           stat_ff;
   logic                 valid_ff;

   // table memories, one read port each, registered read data
   logic signed [DW-1:0] key_mem [TABLE_DEPTH];
   logic signed [DW-1:0] val_mem [TABLE_DEPTH];
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr, rd_addr;
   logic signed [DW-1:0] key_rd, val_rd;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[mem_waddr] <= req_key_ff;
         val_mem[mem_waddr] <= req_val_ff;
      end
      key_rd <= key_mem[rd_addr];
      val_rd <= val_mem[rd_addr];
   end

   // write address is only valid for slots inside the table
   logic wr_in_range;
   always_comb begin
      wr_in_range = (32'(idx_ff) < 32'(TABLE_DEPTH));
      mem_we    = (state_ff == S_WRITE) && wr_in_range;
      mem_waddr = AW'(idx_ff);
      rd_addr   = addr_ff;
   end

   // multiply: |dv| times one half of |dx| per cycle, low half then high half
   logic [HW-1:0]      mx_sel;
   logic [XW+HW-1:0]   part_w;
   assign mx_sel = (cnt_ff == '0) ? mx_ff[HW-1:0] : mx_ff[XW-1:HW];
   assign part_w = (XW+HW)'(mv_ff) * (XW+HW)'(mx_sel);

   // divide step: restoring, one quotient bit per cycle
   logic [PW:0] rem_sh;
   logic        rem_ge;
   assign rem_sh = {rem_ff[PW-1:0], num_ff[PW-1]};
   assign rem_ge = rem_sh >= (PW+1)'(den_ff);

   // final sum with rounding: q = floor((n + d/2)/d) handled by pre-adding d/2
   logic signed [QW+1:0] sum_w;
   always_comb begin
      sum_w = (QW+2)'(signed'(val_lo_ff)) + (QW+2)'(signed'(val_ofs_ff))
            + (neg_ff ? -signed'({2'b00, quo_ff}) : signed'({2'b00, quo_ff}));
   end

   logic [AW:0] mid_w;
   assign mid_w = ({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (start) begin
               idx_ff     <= req_entry_index;
               req_key_ff <= req_entry_key;
               req_val_ff <= req_entry_value;
               x_ff       <= XW'(req_query_key) + XW'(key_ofs_ff);
               n_ff       <= (32'(count_ff) > 32'(TABLE_DEPTH)) ?
                             CW'(TABLE_DEPTH) : count_ff;
               addr_ff    <= '0;
               cnt_ff     <= '0;
               res_ff     <= '0;
               stat_ff    <= stli_pkg::STATUS_OK;
               state_ff   <= req_action ? S_RD_FIRST : S_WRITE;
            end
            S_WRITE: state_ff <= S_DONE;
            S_RD_FIRST: begin
               if (n_ff == '0) begin
                  stat_ff  <= stli_pkg::STATUS_RANGE;
                  state_ff <= S_DONE;
               end else
                  state_ff <= S_CHK_FIRST;
            end
            S_CHK_FIRST: begin
               if (x_ff < XW'(key_rd)) begin
                  stat_ff  <= stli_pkg::STATUS_RANGE;
                  state_ff <= S_DONE;
               end else begin
                  addr_ff  <= AW'(n_ff - 1'b1);
                  lo_ff    <= '0;
                  hi_ff    <= AW'(n_ff - 1'b1);
                  state_ff <= S_RD_LAST;
               end
            end
            S_RD_LAST: state_ff <= S_CHK_LAST;
            S_CHK_LAST: begin
               if (x_ff > XW'(key_rd)) begin
                  stat_ff  <= stli_pkg::STATUS_RANGE;
                  state_ff <= S_DONE;
               end else
                  state_ff <= S_PROBE;
            end
            S_PROBE: begin
               if ((AW+1)'(hi_ff) - (AW+1)'(lo_ff) > (AW+1)'(1)) begin
                  mid_ff   <= AW'(mid_w);
                  addr_ff  <= AW'(mid_w);
                  state_ff <= S_CMP;
               end else begin
                  addr_ff  <= lo_ff;
                  state_ff <= S_RD_PAIR;
               end
            end
            S_CMP: begin
               // read data arrives in the cycle after addr; wait via cnt toggle
               if (cnt_ff == '0) cnt_ff <= QCW'(1);
               else begin
                  cnt_ff <= '0;
                  if (x_ff < XW'(key_rd)) hi_ff <= mid_ff;
                  else lo_ff <= mid_ff;
                  state_ff <= S_PROBE;
               end
            end
            S_RD_PAIR: begin
               // lo address issued; then lo data taken, hi issued; then a wait; then hi data
               if (cnt_ff == '0) begin
                  cnt_ff <= QCW'(1);
               end else if (cnt_ff == QCW'(1)) begin
                  key_lo_ff <= XW'(key_rd);
                  val_lo_ff <= val_rd;
                  addr_ff   <= hi_ff;
                  cnt_ff    <= QCW'(2);
               end else if (cnt_ff == QCW'(2)) begin
                  cnt_ff <= QCW'(3);
               end else begin
                  cnt_ff   <= '0;
                  dk_ff    <= XW'(key_rd) - key_lo_ff;
                  dv_ff    <= XW'(val_rd) - XW'(val_lo_ff);
                  dx_ff    <= x_ff - key_lo_ff;
                  state_ff <= S_DIFF;
               end
            end
            S_DIFF: begin
               neg_ff <= dx_ff[XW-1] ^ dv_ff[XW-1] ^ dk_ff[XW-1];
               mx_ff  <= dx_ff[XW-1] ? XW'(-dx_ff) : XW'(dx_ff);
               mv_ff  <= dv_ff[XW-1] ? XW'(-dv_ff) : XW'(dv_ff);
               den_ff <= dk_ff[XW-1] ? XW'(-dk_ff) : XW'(dk_ff);
               if (dk_ff == '0) begin
                  stat_ff  <= stli_pkg::STATUS_DUP;
                  state_ff <= S_DONE;
               end else
                  state_ff <= S_MUL;
            end
            S_MUL: begin
               // low half plus the rounding term d/2, then the high half
               if (cnt_ff == '0) begin
                  num_ff <= PW'(part_w) + PW'(den_ff >> 1);
                  cnt_ff <= QCW'(1);
               end else begin
                  num_ff   <= num_ff + (PW'(part_w) << HW);
                  rem_ff   <= '0;
                  quo_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (cnt_ff == QCW'(QW)) begin
                  cnt_ff <= '0;
                  if (sum_w > (QW+2)'(signed'(2**(DW-1) - 1)))
                     res_ff <= DW'(2**(DW-1) - 1);
                  else if (sum_w < -(QW+2)'(signed'(2**(DW-1))))
                     res_ff <= DW'(-(2**(DW-1)));
                  else
                     res_ff <= DW'(sum_w);
                  state_ff <= S_DONE;
               end else begin
                  rem_ff <= rem_ge ? rem_sh - (PW+1)'(den_ff) : rem_sh;
                  quo_ff <= {quo_ff[QW-2:0], rem_ge};
                  num_ff <= {num_ff[PW-2:0], 1'b0};
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_DONE: begin
               valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = valid_ff;
   assign rsp_log_result = res_ff;
   assign rsp_status     = stat_ff;

   // no response while a transaction is still being worked on
   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   // accepted start leads to busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("start not taken");
   // error statuses carry a zero result
   a_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != stli_pkg::STATUS_OK) |-> rsp_log_result == '0)
      else $error("nonzero result on error");
endmodule
